// ===== hdl/fpvc_pkg.sv =====
`default_nettype none
package fpvc_pkg;

  localparam int unsigned NumLanes = 3;

  localparam logic [16:0] RstMaxXDisp  = 17'd6554;
  localparam logic [18:0] RstMaxXPos   = 19'd65536;
  localparam logic [16:0] RstMaxSpeed  = 17'd6554;
  localparam logic [16:0] RstAlpha     = 17'd6554;
  localparam logic [23:0] RstMaxForce  = 24'd1310720;

  // 0.0005 in Q0.32.
  localparam logic [22:0] AccGain = 23'd2147484;
  localparam logic [16:0] OneQ16  = 17'd65536;

  typedef enum logic [2:0] {
    LANE_SQ  = 3'd0,
    LANE_DIV = 3'd1,
    LANE_RAW = 3'd2,
    LANE_VEL = 3'd3,
    LANE_CLR = 3'd4
  } lane_op_e;

  typedef struct packed {
    logic     start;
    lane_op_e op;
    logic     zero_end;
  } lane_ctl_t;

  // Shift right by 16, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'd32768) >> 16;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fpvc_sqrt.sv =====
`default_nettype none
module fpvc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q, r_q, bit_q;
  logic [63:0] trial;

  assign trial  = r_q + bit_q;
  assign root_o = r_q[31:0];
  assign done_o = done_q;

  // One result bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
        x_q    <= x_i;
        r_q    <= '0;
        bit_q  <= 64'd1 << 62;
      end else if (busy_q) begin
        if (x_q >= trial) begin
          x_q <= x_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fpvc_lane.sv =====
`default_nettype none
module fpvc_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpvc_pkg::lane_ctl_t ctl_i,
  input  logic signed [31:0]  vec_i,
  input  logic [31:0]         norm_i,
  input  logic signed [17:0]  speed_i,
  input  logic [16:0]         alpha_i,
  output logic [62:0]         sq_o,
  output logic signed [19:0]  vel_o,
  output logic                done_o
);

  logic                busy_q, done_q, neg_q, zero_q;
  fpvc_pkg::lane_op_e  op_q;
  logic [4:0]          step_q;
  logic [62:0]         sq_q;
  logic [49:0]         rem_q;
  logic [16:0]         quo_q;
  logic signed [17:0]  dir_q;
  logic signed [19:0]  vel_q;
  logic signed [35:0]  p1_q;
  logic signed [37:0]  p2_q;
  logic signed [36:0]  p3_q;
  logic signed [18:0]  tgt_q;

  logic [31:0]         mag;
  logic [63:0]         sq_full;
  logic [49:0]         sub;
  logic [16:0]         quo_n;
  logic signed [17:0]  oma, alpha_s;
  logic signed [38:0]  acc;
  logic signed [63:0]  tgt64, vel64;

  always_comb begin
    mag     = vec_i[31] ? 32'(-vec_i) : 32'(vec_i);
    sq_full = mag * mag;
    sub     = rem_q - (50'(norm_i) << step_q);
    quo_n   = sub[49] ? quo_q : (quo_q | (17'd1 << step_q));
    oma     = $signed({1'b0, 17'(fpvc_pkg::OneQ16 - alpha_i)});
    alpha_s = $signed({1'b0, alpha_i});
    acc     = 39'(p2_q) + 39'(p3_q);
    tgt64   = fpvc_pkg::rnd16(64'(p1_q));
    vel64   = fpvc_pkg::rnd16(64'(acc));
  end

  assign sq_o   = sq_q;
  assign vel_o  = vel_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      zero_q <= 1'b0;
      op_q   <= fpvc_pkg::LANE_CLR;
      step_q <= '0;
      sq_q   <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dir_q  <= '0;
      vel_q  <= '0;
      p1_q   <= '0;
      p2_q   <= '0;
      p3_q   <= '0;
      tgt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        op_q <= ctl_i.op;
        case (ctl_i.op)
          fpvc_pkg::LANE_SQ: begin
            sq_q   <= sq_full[62:0];
            done_q <= 1'b1;
          end
          fpvc_pkg::LANE_DIV: begin
            // Rounded quotient (|v| * 2^16 + m/2) / m fits 17 bits since |v| <= m.
            rem_q  <= 50'({mag, 16'd0}) + 50'(norm_i >> 1);
            quo_q  <= '0;
            neg_q  <= vec_i[31];
            step_q <= 5'd16;
            busy_q <= 1'b1;
          end
          fpvc_pkg::LANE_RAW: begin
            dir_q  <= vec_i[17:0];
            done_q <= 1'b1;
          end
          fpvc_pkg::LANE_VEL: begin
            p1_q   <= speed_i * dir_q;
            zero_q <= ctl_i.zero_end;
            step_q <= '0;
            busy_q <= 1'b1;
          end
          default: begin
            vel_q  <= '0;
            done_q <= 1'b1;
          end
        endcase
      end else if (busy_q) begin
        case (op_q)
          fpvc_pkg::LANE_DIV: begin
            if (!sub[49]) begin
              rem_q <= sub;
            end
            quo_q <= quo_n;
            if (step_q == 5'd0) begin
              dir_q  <= neg_q ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              step_q <= step_q - 5'd1;
            end
          end
          fpvc_pkg::LANE_VEL: begin
            step_q <= step_q + 5'd1;
            case (step_q)
              5'd0: begin
                tgt_q <= tgt64[18:0];
                p2_q  <= oma * vel_q;
              end
              5'd1: begin
                p3_q <= alpha_s * tgt_q;
              end
              default: begin
                vel_q  <= zero_q ? '0 : vel64[19:0];
                busy_q <= 1'b0;
                done_q <= 1'b1;
              end
            endcase
          end
          default: begin
            busy_q <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/force_push_velocity_ctrl_top.sv =====
// Channel | Direction | Handshake             | Payload
// cfg     | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
// in      | in        | in_valid_i/in_ready_o | cmd_i, pos_x_i, dt_i, vec_*_i, force_goal_in_i,
//         |           |                       | duration_in_i
// out     | out       | out_valid_o/out_ready_i | vel_x_o, vel_y_o, vel_z_o, moving_o
//
// One transaction at a time. A set target runs the lane squares, the square root and
// the division in each of the three lanes. A force sample runs the squares and the square
// root; a tick runs the acceleration, speed and velocity steps, or only a clear when not moving.
// Reset clears all motion state and loads the register defaults.
// The result register lets a new input transaction start while a result waits.
`default_nettype none
module force_push_velocity_ctrl_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [18:0] pos_x_i,
  input  logic [23:0]        dt_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] force_goal_in_i,
  input  logic [31:0]        duration_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic               moving_o
);

  localparam int unsigned NL = fpvc_pkg::NumLanes;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_FORCE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_MAX_X_DISP = 3'd0,
    CFG_MAX_X_POS  = 3'd1,
    CFG_MAX_SPEED  = 3'd2,
    CFG_ALPHA      = 3'd3,
    CFG_MAX_FORCE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_SQ    = 16'h0002,
    S_SQW   = 16'h0004,
    S_SUM   = 16'h0008,
    S_SQRTW = 16'h0010,
    S_DIV   = 16'h0020,
    S_DIVW  = 16'h0040,
    S_TCHK  = 16'h0080,
    S_ACC1  = 16'h0100,
    S_ACC2  = 16'h0200,
    S_SPD1  = 16'h0400,
    S_SPD2  = 16'h0800,
    S_SPD3  = 16'h1000,
    S_VEL   = 16'h2000,
    S_VELW  = 16'h4000,
    S_OUT   = 16'h8000
  } state_e;

  state_e              state_q;
  logic [16:0]         max_x_disp_q, max_speed_q, alpha_q;
  logic signed [18:0]  max_x_pos_q;
  logic [23:0]         max_force_q;

  logic signed [31:0]  vec_q [NL];
  logic signed [18:0]  px_q, start_q;
  logic [23:0]         dt_q, goal_q;
  logic [31:0]         dur_q, meas_q, norm_q;
  logic [32:0]         elapsed_q;
  logic [63:0]         sum_q;
  logic signed [47:0]  accel_q;
  logic signed [17:0]  speed_q;
  logic signed [57:0]  prod_q;
  logic [47:0]         hi_q, lo_q;
  logic                move_q, capture_q, is_set_q, stop_q;
  logic                out_valid_q, moving_q;
  logic signed [31:0]  vel_q [NL];

  fpvc_pkg::lane_ctl_t lane_ctl;
  logic [62:0]         lane_sq   [NL];
  logic signed [19:0]  lane_vel  [NL];
  logic [NL-1:0]       lane_done;
  logic                all_done;
  logic                sqrt_start, sqrt_done;
  logic [31:0]         sqrt_root;
  logic [16:0]         alpha_eff;

  logic                in_fire;
  logic signed [18:0]  start_eff;
  logic signed [19:0]  disp;
  logic [19:0]         disp_mag;
  logic                move_n;
  logic signed [33:0]  err;
  logic signed [63:0]  acc_inc;
  logic signed [48:0]  acc_sum;
  logic [47:0]         acc_mag;
  logic [48:0]         spd_lo, spd_r;
  logic signed [34:0]  spd_step, spd_sum, spd_lim;
  logic [33:0]         el_sum;
  logic [32:0]         el_sat;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign all_done   = &lane_done;
  assign alpha_eff  = (alpha_q > fpvc_pkg::OneQ16) ? fpvc_pkg::OneQ16 : alpha_q;

  always_comb begin
    start_eff = capture_q ? px_q : start_q;
    disp      = 20'(start_eff) - 20'(px_q);
    disp_mag  = disp[19] ? 20'(-disp) : 20'(disp);
    move_n    = move_q & ~((disp_mag > 20'(max_x_disp_q)) | (px_q > max_x_pos_q));

    err      = $signed(34'(goal_q)) - $signed(34'(meas_q));
    acc_inc  = fpvc_pkg::rnd16(64'(prod_q));
    acc_sum  = 49'(accel_q) + 49'(acc_inc);
    acc_mag  = accel_q[47] ? 48'(-accel_q) : 48'(accel_q);

    // accel * dt split into two 24-bit halves, rounded back to Q16.16.
    spd_lo   = (49'(lo_q) + (49'd1 << 39)) >> 24;
    spd_r    = (49'(hi_q) + spd_lo) >> 16;
    spd_step = accel_q[47] ? -$signed(35'(spd_r)) : $signed(35'(spd_r));
    spd_sum  = 35'(speed_q) + spd_step;
    spd_lim  = $signed(35'(max_speed_q));

    el_sum   = 34'(elapsed_q) + 34'(dt_q);
    el_sat   = el_sum[33] ? '1 : el_sum[32:0];
  end

  always_comb begin
    lane_ctl.start    = 1'b0;
    lane_ctl.op       = fpvc_pkg::LANE_CLR;
    lane_ctl.zero_end = stop_q;
    sqrt_start        = (state_q == S_SUM);
    case (state_q)
      S_SQ: begin
        lane_ctl.start = 1'b1;
        lane_ctl.op    = fpvc_pkg::LANE_SQ;
      end
      S_DIV: begin
        lane_ctl.start = 1'b1;
        lane_ctl.op    = (norm_q == 32'd0 || norm_q == 32'(fpvc_pkg::OneQ16)) ?
                         fpvc_pkg::LANE_RAW : fpvc_pkg::LANE_DIV;
      end
      S_TCHK: begin
        lane_ctl.start = ~move_n;
        lane_ctl.op    = fpvc_pkg::LANE_CLR;
      end
      S_VEL: begin
        lane_ctl.start = 1'b1;
        lane_ctl.op    = fpvc_pkg::LANE_VEL;
      end
      default: begin
        lane_ctl.start = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < NL; g++) begin : gen_lane
    fpvc_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (lane_ctl),
      .vec_i   (vec_q[g]),
      .norm_i  (norm_q),
      .speed_i (speed_q),
      .alpha_i (alpha_eff),
      .sq_o    (lane_sq[g]),
      .vel_o   (lane_vel[g]),
      .done_o  (lane_done[g])
    );
  end

  fpvc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sum_q),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_disp_q <= fpvc_pkg::RstMaxXDisp;
      max_x_pos_q  <= fpvc_pkg::RstMaxXPos;
      max_speed_q  <= fpvc_pkg::RstMaxSpeed;
      alpha_q      <= fpvc_pkg::RstAlpha;
      max_force_q  <= fpvc_pkg::RstMaxForce;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_X_DISP: max_x_disp_q <= cfg_data_i[16:0];
        CFG_MAX_X_POS:  max_x_pos_q  <= cfg_data_i[18:0];
        CFG_MAX_SPEED:  max_speed_q  <= cfg_data_i[16:0];
        CFG_ALPHA:      alpha_q      <= cfg_data_i[16:0];
        CFG_MAX_FORCE:  max_force_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < NL; i++) begin
        vec_q[i] <= '0;
        vel_q[i] <= '0;
      end
      px_q        <= '0;
      start_q     <= '0;
      dt_q        <= '0;
      goal_q      <= '0;
      dur_q       <= '0;
      meas_q      <= '0;
      norm_q      <= '0;
      elapsed_q   <= '0;
      sum_q       <= '0;
      accel_q     <= '0;
      speed_q     <= '0;
      prod_q      <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      move_q      <= 1'b0;
      capture_q   <= 1'b1;
      is_set_q    <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      moving_q    <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            vec_q[0] <= vec_x_i;
            vec_q[1] <= vec_y_i;
            vec_q[2] <= vec_z_i;
            px_q     <= pos_x_i;
            dt_q     <= dt_i;
            case (cmd_i)
              CMD_TICK: begin
                state_q <= S_TCHK;
              end
              CMD_SET: begin
                if (force_goal_in_i[31]) begin
                  goal_q <= '0;
                end else if (force_goal_in_i[30:0] > 31'(max_force_q)) begin
                  goal_q <= max_force_q;
                end else begin
                  goal_q <= force_goal_in_i[23:0];
                end
                dur_q     <= duration_in_i;
                elapsed_q <= '0;
                capture_q <= 1'b1;
                move_q    <= 1'b1;
                is_set_q  <= 1'b1;
                state_q   <= S_SQ;
              end
              CMD_FORCE: begin
                is_set_q <= 1'b0;
                state_q  <= S_SQ;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_SQ: state_q <= S_SQW;
        S_SQW: begin
          if (all_done) begin
            sum_q   <= 64'(lane_sq[0]) + 64'(lane_sq[1]) + 64'(lane_sq[2]);
            state_q <= S_SUM;
          end
        end
        S_SUM: state_q <= S_SQRTW;
        S_SQRTW: begin
          if (sqrt_done) begin
            norm_q <= sqrt_root;
            if (is_set_q) begin
              state_q <= S_DIV;
            end else begin
              meas_q  <= sqrt_root;
              state_q <= S_IDLE;
            end
          end
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: begin
          if (all_done) begin
            state_q <= S_IDLE;
          end
        end
        S_TCHK: begin
          start_q   <= start_eff;
          capture_q <= 1'b0;
          move_q    <= move_n;
          state_q   <= move_n ? S_ACC1 : S_VELW;
        end
        S_ACC1: begin
          prod_q  <= err * $signed({1'b0, fpvc_pkg::AccGain});
          state_q <= S_ACC2;
        end
        S_ACC2: begin
          if (acc_sum[48] != acc_sum[47]) begin
            accel_q <= acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          end else begin
            accel_q <= acc_sum[47:0];
          end
          state_q <= S_SPD1;
        end
        S_SPD1: begin
          hi_q    <= acc_mag[47:24] * dt_q;
          state_q <= S_SPD2;
        end
        S_SPD2: begin
          lo_q    <= acc_mag[23:0] * dt_q;
          state_q <= S_SPD3;
        end
        S_SPD3: begin
          if (spd_sum > spd_lim) begin
            speed_q <= spd_lim[17:0];
          end else if (spd_sum < -spd_lim) begin
            speed_q <= 18'(-spd_lim);
          end else begin
            speed_q <= spd_sum[17:0];
          end
          elapsed_q <= el_sat;
          stop_q    <= (el_sat >= 33'(dur_q));
          move_q    <= (el_sat < 33'(dur_q));
          state_q   <= S_VEL;
        end
        S_VEL: state_q <= S_VELW;
        S_VELW: begin
          if (all_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            for (int i = 0; i < NL; i++) begin
              vel_q[i] <= 32'(lane_vel[i]);
            end
            moving_q    <= move_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign vel_x_o     = vel_q[0];
  assign vel_y_o     = vel_q[1];
  assign vel_z_o     = vel_q[2];
  assign moving_o    = moving_q;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
  import fpvc_pkg::*;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_TARGET = 2'd1,
    CMD_FORCE  = 2'd2,
    CMD_UNUSED = 2'd3
  } push_cmd_e;

  typedef enum logic [2:0] {
    REG_MAX_X_DISP = 3'd0,
    REG_MAX_X_POS  = 3'd1,
    REG_MAX_SPEED  = 3'd2,
    REG_ALPHA      = 3'd3,
    REG_MAX_FORCE  = 3'd4
  } push_reg_e;

  typedef struct packed {
    push_cmd_e          cmd;
    logic signed [18:0] pos_x;
    logic [23:0]        dt;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] goal;
    logic [31:0]        dur;
  } push_item_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               moving;
  } vel_cmd_t;

  typedef struct packed {
    push_item_t item;
    logic       typed;
    vel_cmd_t   want;
  } dir_row_t;

  localparam longint AccLimit = 64'sh7FFF_FFFF_FFFF;
  localparam logic [63:0] ElapsedSat = 64'h1_FFFF_FFFF;
  localparam int CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  logic signed [18:0] pos_x_i = '0;
  logic [23:0] dt_i = '0;
  logic signed [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [31:0] force_goal_in_i = '0;
  logic [31:0] duration_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] vel_x_o, vel_y_o, vel_z_o;
  logic moving_o;

  force_push_velocity_ctrl_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Controller state as the predictor sees it.
  logic [16:0] cfg_disp, cfg_speed, cfg_alpha;
  logic signed [18:0] cfg_xpos;
  logic [23:0] cfg_force;
  longint accel_q, speed_q, goal_q, start_x_q;
  longint vel_q[3], dir_q[3];
  logic [63:0] fmeas_q, run_dur_q, elapsed_q;
  logic moving_q, capture_q;

  vel_cmd_t vel_expected_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  bit no_idle = 0;

  function automatic longint round_shift(longint v, int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 << (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] magnitude3(longint a, longint b, longint c);
    logic [63:0] ma, mb, mc;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    mc = c < 0 ? -c : c;
    return isqrt(ma * ma + mb * mb + mc * mc);
  endfunction

  // Q16.32 acceleration times a 2^-24 s period, rounded to Q16.16.
  function automatic longint accel_over_dt(longint a, logic [23:0] dt);
    logic [63:0] am, hi, lo, r;
    am = a < 0 ? -a : a;
    hi = (am >> 24) * dt;
    lo = (am & 64'hFF_FFFF) * dt;
    r = (hi + ((lo + (64'd1 << 39)) >> 24)) >> 16;
    return a < 0 ? -longint'(r) : longint'(r);
  endfunction

  task automatic reset_push_model();
    cfg_disp = RstMaxXDisp;
    cfg_xpos = RstMaxXPos;
    cfg_speed = RstMaxSpeed;
    cfg_alpha = RstAlpha;
    cfg_force = RstMaxForce;
    accel_q = 0; speed_q = 0; goal_q = 0; start_x_q = 0;
    fmeas_q = 0; run_dur_q = 0; elapsed_q = 0;
    moving_q = 0; capture_q = 1;
    for (int i = 0; i < 3; i++) begin
      vel_q[i] = 0;
      dir_q[i] = 0;
    end
  endtask

  // Advances the controller state by one item; returns 1 when a tick yields a command.
  function automatic bit step_push_model(push_item_t it, output vel_cmd_t res);
    longint v[3], px, err, alpha, lim, tgt, d;
    logic [63:0] m, q, mv;
    res = '0;
    v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
    case (it.cmd)
      CMD_TARGET: begin
        m = magnitude3(v[0], v[1], v[2]);
        for (int i = 0; i < 3; i++) begin
          if (m != 0 && m != 64'd65536) begin
            mv = v[i] < 0 ? -v[i] : v[i];
            q = (mv * 64'd65536 + (m >> 1)) / m;
            dir_q[i] = v[i] < 0 ? -longint'(q) : longint'(q);
          end else begin
            dir_q[i] = v[i];
          end
        end
        goal_q = it.goal < 0 ? 0 : it.goal;
        if (goal_q > longint'(cfg_force)) goal_q = cfg_force;
        run_dur_q = it.dur;
        elapsed_q = 0;
        capture_q = 1;
        moving_q = 1;
        return 0;
      end
      CMD_FORCE: begin
        m = magnitude3(v[0], v[1], v[2]);
        fmeas_q = m > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : m;
        return 0;
      end
      CMD_UNUSED: return 0;
      default: ;
    endcase
    px = it.pos_x;
    if (capture_q) begin
      start_x_q = px;
      capture_q = 0;
    end
    d = start_x_q - px;
    if (d < 0) d = -d;
    if (d > longint'(cfg_disp) || px > longint'(cfg_xpos)) moving_q = 0;
    if (moving_q) begin
      err = goal_q - longint'(fmeas_q);
      alpha = cfg_alpha > 17'd65536 ? 65536 : longint'(cfg_alpha);
      lim = cfg_speed;
      accel_q += round_shift(err * 2147484, 16);
      if (accel_q > AccLimit) accel_q = AccLimit;
      if (accel_q < -AccLimit - 1) accel_q = -AccLimit - 1;
      speed_q += accel_over_dt(accel_q, it.dt);
      if (speed_q > lim) speed_q = lim;
      if (speed_q < -lim) speed_q = -lim;
      for (int i = 0; i < 3; i++) begin
        tgt = round_shift(speed_q * dir_q[i], 16);
        vel_q[i] = round_shift((65536 - alpha) * vel_q[i] + alpha * tgt, 16);
      end
      elapsed_q += it.dt;
      if (elapsed_q > ElapsedSat) elapsed_q = ElapsedSat;
      if (elapsed_q >= run_dur_q) begin
        moving_q = 0;
        for (int i = 0; i < 3; i++) vel_q[i] = 0;
      end
    end else begin
      for (int i = 0; i < 3; i++) vel_q[i] = 0;
    end
    res.vx = vel_q[0][31:0];
    res.vy = vel_q[1][31:0];
    res.vz = vel_q[2][31:0];
    res.moving = moving_q;
    return 1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0d] mismatch on %s: got %0d, expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Presents one item and waits for its transaction; the valid stays high on return.
  task automatic send_item(push_item_t it, bit typed = 0, vel_cmd_t want = '0);
    vel_cmd_t res;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= it.cmd;
    pos_x_i <= it.pos_x;
    dt_i <= it.dt;
    vec_x_i <= it.vx;
    vec_y_i <= it.vy;
    vec_z_i <= it.vz;
    force_goal_in_i <= it.goal;
    duration_in_i <= it.dur;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (step_push_model(it, res)) vel_expected_q.push_back(typed ? want : res);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (vel_expected_q.size() != 0) @(posedge clk_i);
    // A set target or force sample may still be in progress.
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_reg(push_reg_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAX_X_DISP: cfg_disp = val[16:0];
      REG_MAX_X_POS:  cfg_xpos = val[18:0];
      REG_MAX_SPEED:  cfg_speed = val[16:0];
      REG_ALPHA:      cfg_alpha = val[16:0];
      REG_MAX_FORCE:  cfg_force = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic push_item_t random_item();
    push_item_t it;
    it.cmd = push_cmd_e'($urandom_range(0, 3));
    it.pos_x = $urandom;
    it.dt = $urandom;
    it.vx = $urandom;
    it.vy = $urandom;
    it.vz = $urandom;
    it.goal = $urandom;
    it.dur = $urandom;
    return it;
  endfunction

  // One push: arm, then ticks near the start position with force samples and random items mixed in.
  task automatic run_push();
    push_item_t it;
    int base, n;
    it = random_item();
    it.cmd = CMD_TARGET;
    if ($urandom_range(0, 3) == 0) begin
      it.vx = $signed($urandom_range(0, 8)) - 4 <<< 16;
      it.vy = $signed($urandom_range(0, 8)) - 4 <<< 16;
      it.vz = 0;
    end
    it.goal = $urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 13107200);
    it.dur = $urandom_range(1 << 18, 1 << 25);
    send_item(it);
    base = $signed($urandom_range(0, 262144)) - 131072;
    n = $urandom_range(4, 16);
    for (int k = 0; k < n; k++) begin
      it = random_item();
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          it.cmd = CMD_FORCE;
          if ($urandom_range(0, 1)) begin
            it.vx = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            it.vy = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            it.vz = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
          end
        end
        3: ;
        default: begin
          it.cmd = CMD_TICK;
          it.pos_x = base + $signed($urandom_range(0, 4000)) - 2000;
          it.dt = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1 << 12, 1 << 20);
        end
      endcase
      send_item(it);
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    vel_cmd_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (vel_expected_q.size() == 0) begin
          $display("[%0d] unexpected velocity command", cycles);
          errors++;
        end else begin
          w = vel_expected_q.pop_front();
          if (vel_x_o !== w.vx) report_mismatch("vel_x", vel_x_o, w.vx);
          if (vel_y_o !== w.vy) report_mismatch("vel_y", vel_y_o, w.vy);
          if (vel_z_o !== w.vz) report_mismatch("vel_z", vel_z_o, w.vz);
          if (moving_o !== w.moving) report_mismatch("moving", moving_o, w.moving);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  localparam vel_cmd_t Idle = '{vx: 0, vy: 0, vz: 0, moving: 1'b0};
  localparam vel_cmd_t ArmedStill = '{vx: 0, vy: 0, vz: 0, moving: 1'b1};

  dir_row_t dir_tbl[19] = '{
    '{'{CMD_TICK, 19'sd0, 24'd1000, 0, 0, 0, 0, 0}, 1'b1, Idle},
    '{'{CMD_UNUSED, -19'sd5, 24'hFFFFFF, -1, -1, -1, -1, 32'hFFFFFFFF}, 1'b0, Idle},
    '{'{CMD_TARGET, 19'sd0, 24'd0, 0, 0, 0, 32'sd1000 <<< 16, 32'd1 << 24}, 1'b0, Idle},
    '{'{CMD_TICK, 19'sd0, 24'd1 << 20, 0, 0, 0, 0, 0}, 1'b1, ArmedStill},
    '{'{CMD_FORCE, 19'sd0, 24'd0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0},
      1'b0, Idle},
    '{'{CMD_TARGET, 19'sd0, 24'd0, 32'sd65536, 0, 0, -32'sd5, 32'd0}, 1'b0, Idle},
    '{'{CMD_TICK, 19'sd0, 24'd5000, 0, 0, 0, 0, 0}, 1'b1, Idle},
    '{'{CMD_TARGET, 19'sd0, 24'd0, 32'h80000000, 32'h7FFFFFFF, 32'sd12345, 32'h7FFFFFFF,
      32'hFFFFFFFF}, 1'b0, Idle},
    '{'{CMD_TICK, 19'sd100, 24'hFFFFFF, 0, 0, 0, 0, 0}, 1'b0, Idle},
    '{'{CMD_TICK, 19'sd200, 24'hFFFFFF, 0, 0, 0, 0, 0}, 1'b0, Idle},
    '{'{CMD_FORCE, 19'sd0, 24'd0, 32'sd3 <<< 16, 32'sd4 <<< 16, 0, 0, 0}, 1'b0, Idle},
    '{'{CMD_TICK, 19'sd300, 24'd1 << 20, 0, 0, 0, 0, 0}, 1'b0, Idle},
    '{'{CMD_TICK, 19'sd131072, 24'd1000, 0, 0, 0, 0, 0}, 1'b1, Idle},
    '{'{CMD_TICK, -19'sd131072, 24'd1000, 0, 0, 0, 0, 0}, 1'b1, Idle},
    '{'{CMD_TARGET, 19'sd0, 24'd0, 32'sd65536, 32'sd65536, 32'sd65536, 32'sd1 <<< 20,
      32'd1 << 22}, 1'b0, Idle},
    '{'{CMD_TICK, -19'sd131072, 24'd1 << 18, 0, 0, 0, 0, 0}, 1'b0, Idle},
    '{'{CMD_TICK, -19'sd121072, 24'd1 << 18, 0, 0, 0, 0, 0}, 1'b1, Idle},
    '{'{CMD_TARGET, 19'sd0, 24'd0, 0, 0, -32'sd131072, 32'sd1 <<< 16, 32'd1 << 23},
      1'b0, Idle},
    '{'{CMD_TICK, 19'sd7, 24'd1 << 21, 0, 0, 0, 0, 0}, 1'b0, Idle}
  };

  initial begin
    reset_push_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tbl[r]) send_item(dir_tbl[r].item, dir_tbl[r].typed, dir_tbl[r].want);
    drain_and_settle();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_MAX_X_DISP, 24'd65536);
          write_reg(REG_MAX_X_POS, 24'd131072);
          write_reg(REG_MAX_SPEED, 24'd65536);
          write_reg(REG_ALPHA, 24'd65536);
          write_reg(REG_MAX_FORCE, 24'd13107200);
        end
        2: begin
          write_reg(REG_MAX_X_DISP, 24'd0);
          write_reg(REG_MAX_X_POS, 24'(-131072));
          write_reg(REG_MAX_SPEED, 24'd0);
          write_reg(REG_ALPHA, 24'd0);
          write_reg(REG_MAX_FORCE, 24'd0);
        end
        3: begin
          write_reg(REG_MAX_X_DISP, 24'd20000);
          write_reg(REG_MAX_X_POS, 24'd131072);
          write_reg(REG_MAX_SPEED, 24'd40000);
          write_reg(REG_ALPHA, 24'd131071);
          write_reg(REG_MAX_FORCE, 24'd6553600);
        end
        4, 5: begin
          write_reg(REG_MAX_X_DISP, $urandom_range(1000, 65536));
          write_reg(REG_MAX_X_POS, 24'($signed($urandom_range(0, 262144)) - 131072));
          write_reg(REG_MAX_SPEED, $urandom_range(0, 65536));
          write_reg(REG_ALPHA, $urandom_range(0, 131071));
          write_reg(REG_MAX_FORCE, $urandom_range(0, 13107200));
        end
        default: ;
      endcase
      no_idle = (ph == 5);
      while (items_sent < 20 + 280 * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0) send_item(random_item());
        else run_push();
      end
      drain_and_settle();
    end
    $display("%0d items sent, %0d velocity commands checked over six register settings,",
             items_sent, results_seen);
    $display("including register extremes, saturated speed and accel, and limit stops.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/fpvc_pkg.sv
hdl/fpvc_sqrt.sv
hdl/fpvc_lane.sv
hdl/force_push_velocity_ctrl_top.sv
test/tb.sv
